// File: rtl/core/qrs_pkg.sv
package qrs_pkg;

  // Classification of the equation, as reported on root_case_o.
  typedef enum logic [1:0] {
    CaseTwoReal    = 2'd0,
    CaseDouble     = 2'd1,
    CaseComplex    = 2'd2,
    CaseDegenerate = 2'd3
  } root_case_e;

  // Pipeline control handed to each sub-pipeline: the valid bit entering its
  // first stage and the global advance enable.
  typedef struct packed {
    logic valid;
    logic en;
  } pipe_ctl_t;

endpackage

// File: rtl/core/qrs_isqrt.sv
module qrs_isqrt #(
  parameter int RAD_W = 66,
  parameter int SB_W  = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qrs_pkg::pipe_ctl_t       ctl_i,
  input  logic [RAD_W-1:0]         rad_i,
  input  logic [SB_W-1:0]          sb_i,
  output logic                     valid_o,
  output logic [RAD_W/2-1:0]       root_o,
  output logic [SB_W-1:0]          sb_o
);

  localparam int ROOT_W = RAD_W / 2;

  // One root bit per stage, most significant first. rem holds the radicand
  // minus the square of the partial root.
  logic [RAD_W-1:0]  rem_q [ROOT_W+1];
  logic [ROOT_W-1:0] res_q [ROOT_W+1];
  logic [SB_W-1:0]   sb_q  [ROOT_W+1];
  logic              vld_q [ROOT_W+1];

  assign rem_q[0] = rad_i;
  assign res_q[0] = '0;
  assign sb_q[0]  = sb_i;
  assign vld_q[0] = ctl_i.valid;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int I = ROOT_W - 1 - k;
    logic [RAD_W-1:0] trial;
    logic             ge;

    // (res + 2^I)^2 - res^2 = res * 2^(I+1) + 2^(2I)
    assign trial = (RAD_W'(res_q[k]) << (I + 1)) | (RAD_W'(1) << (2 * I));
    assign ge    = rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k+1] <= ge ? rem_q[k] - trial : rem_q[k];
        res_q[k+1] <= ge ? (res_q[k] | (ROOT_W'(1) << I)) : res_q[k];
        sb_q[k+1]  <= sb_q[k];
      end
    end
  end

  assign valid_o = vld_q[ROOT_W];
  assign root_o  = res_q[ROOT_W];
  assign sb_o    = sb_q[ROOT_W];

endmodule

// File: rtl/core/qrs_div.sv
module qrs_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 33,
  parameter int SB_W  = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qrs_pkg::pipe_ctl_t   ctl_i,
  input  logic [NUM_W-1:0]     num0_i,
  input  logic [NUM_W-1:0]     num1_i,
  input  logic [DEN_W-1:0]     den_i,
  input  logic [SB_W-1:0]      sb_i,
  output logic                 valid_o,
  output logic [NUM_W-1:0]     quo0_o,
  output logic [NUM_W-1:0]     quo1_o,
  output logic [SB_W-1:0]      sb_o
);

  // Two restoring dividers side by side sharing one divisor, one quotient
  // bit per stage.
  logic [NUM_W-1:0] num_q [NUM_W+1][2];
  logic [NUM_W-1:0] quo_q [NUM_W+1][2];
  logic [DEN_W-1:0] rem_q [NUM_W+1][2];
  logic [DEN_W-1:0] den_q [NUM_W+1];
  logic [SB_W-1:0]  sb_q  [NUM_W+1];
  logic             vld_q [NUM_W+1];

  assign num_q[0][0] = num0_i;
  assign num_q[0][1] = num1_i;
  assign quo_q[0][0] = '0;
  assign quo_q[0][1] = '0;
  assign rem_q[0][0] = '0;
  assign rem_q[0][1] = '0;
  assign den_q[0]    = den_i;
  assign sb_q[0]     = sb_i;
  assign vld_q[0]    = ctl_i.valid;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    localparam int J = NUM_W - 1 - k;
    logic [DEN_W:0] part [2];
    logic           ge   [2];

    for (genvar l = 0; l < 2; l++) begin : g_lane
      assign part[l] = {rem_q[k][l], num_q[k][l][J]};
      assign ge[l]   = part[l] >= {1'b0, den_q[k]};

      always_ff @(posedge clk_i) begin
        if (ctl_i.en) begin
          rem_q[k+1][l] <= ge[l] ? DEN_W'(part[l] - {1'b0, den_q[k]}) : DEN_W'(part[l]);
          quo_q[k+1][l] <= ge[l] ? (quo_q[k][l] | (NUM_W'(1) << J)) : quo_q[k][l];
          num_q[k+1][l] <= num_q[k][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        den_q[k+1] <= den_q[k];
        sb_q[k+1]  <= sb_q[k];
      end
    end
  end

  assign valid_o = vld_q[NUM_W];
  assign quo0_o  = quo_q[NUM_W][0];
  assign quo1_o  = quo_q[NUM_W][1];
  assign sb_o    = sb_q[NUM_W];

endmodule

// File: rtl/core/quadratic_root_solver_core.sv
// Quadratic root solver for a*x^2 + b*x + c = 0 on signed fixed-point
// coefficients (COEF_WIDTH bits, FRAC_BITS fraction bits).
// Input channel: in_valid_i / in_ready_o carry coef_a_i, coef_b_i, coef_c_i.
// Output channel: out_valid_o / out_ready_i carry root_case_o, first_real_o,
// second_real_o, imag_part_o and saturated_o, one result per equation.
// Throughput is one equation per cycle while the output is not stalled.
// An equation passes four stages of split, multiply, sum and discriminant,
// then the bit-per-stage square root (COEF_WIDTH+1 stages) and the
// bit-per-stage dividers (COEF_WIDTH+FRAC_BITS+3 stages).
// The whole pipeline advances together; while a result waits on the output
// with out_ready_i low, every stage holds and in_ready_o is low, so nothing
// is dropped or repeated. Bubbles move on whenever the output is empty or
// taken. Reset clears all valid bits; the block is ready in the first cycle
// after reset is released. An equation with a equal to zero reports the
// degenerate case with all values and the saturation flag zero.
module quadratic_root_solver_core #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COEF_WIDTH-1:0] coef_a_i,
  input  logic signed [COEF_WIDTH-1:0] coef_b_i,
  input  logic signed [COEF_WIDTH-1:0] coef_c_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   root_case_o,
  output logic signed [COEF_WIDTH-1:0] first_real_o,
  output logic signed [COEF_WIDTH-1:0] second_real_o,
  output logic signed [COEF_WIDTH-1:0] imag_part_o,
  output logic                         saturated_o
);

  localparam int W     = COEF_WIDTH;
  localparam int H     = (W + 1) / 2;
  localparam int HW    = W - H;
  localparam int PW    = 2 * W;
  localparam int DW    = 2 * W + 2;
  localparam int RW    = W + 1;
  localparam int NW    = W + 3;
  localparam int QW    = NW + FRAC_BITS;
  localparam int SB1_W = 2 * W + 4;
  localparam int SB2_W = 4;
  localparam logic [QW-1:0] PosLim = (QW'(1) << (W - 1)) - QW'(1);

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: signs and magnitudes.
  logic          v1_q;
  logic          an1_q, bn1_q, cn1_q;
  logic [W-1:0]  am1_q, bm1_q, cm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      an1_q <= coef_a_i[W-1];
      bn1_q <= coef_b_i[W-1];
      cn1_q <= coef_c_i[W-1];
      am1_q <= coef_a_i[W-1] ? W'(-coef_a_i) : coef_a_i;
      bm1_q <= coef_b_i[W-1] ? W'(-coef_b_i) : coef_b_i;
      cm1_q <= coef_c_i[W-1] ? W'(-coef_c_i) : coef_c_i;
    end
  end

  // Stage 2: half-width partial products of b*b and a*c.
  logic            v2_q, an2_q, bn2_q, cn2_q, az2_q;
  logic [W-1:0]    am2_q, bm2_q;
  logic [2*H-1:0]  bb_ll_q, ac_ll_q;
  logic [W-1:0]    bb_lh_q, ac_lh_q, ac_hl_q;
  logic [2*HW-1:0] bb_hh_q, ac_hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      an2_q   <= an1_q;
      bn2_q   <= bn1_q;
      cn2_q   <= cn1_q;
      az2_q   <= am1_q == '0;
      am2_q   <= am1_q;
      bm2_q   <= bm1_q;
      bb_ll_q <= bm1_q[H-1:0] * bm1_q[H-1:0];
      bb_lh_q <= bm1_q[H-1:0] * bm1_q[W-1:H];
      bb_hh_q <= bm1_q[W-1:H] * bm1_q[W-1:H];
      ac_ll_q <= am1_q[H-1:0] * cm1_q[H-1:0];
      ac_lh_q <= am1_q[H-1:0] * cm1_q[W-1:H];
      ac_hl_q <= am1_q[W-1:H] * cm1_q[H-1:0];
      ac_hh_q <= am1_q[W-1:H] * cm1_q[W-1:H];
    end
  end

  // Stage 3: full products.
  logic          v3_q, an3_q, bn3_q, sg3_q, az3_q;
  logic [W-1:0]  am3_q, bm3_q;
  logic [PW-1:0] bb3_q;
  logic [DW-1:0] ac4_3_q;
  logic [PW-1:0] ac_full;

  assign ac_full = (PW'(ac_hh_q) << (2 * H))
                 + ((PW'(ac_lh_q) + PW'(ac_hl_q)) << H)
                 + PW'(ac_ll_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      an3_q   <= an2_q;
      bn3_q   <= bn2_q;
      sg3_q   <= an2_q ^ cn2_q;
      az3_q   <= az2_q;
      am3_q   <= am2_q;
      bm3_q   <= bm2_q;
      bb3_q   <= (PW'(bb_hh_q) << (2 * H)) + (PW'(bb_lh_q) << (H + 1)) + PW'(bb_ll_q);
      ac4_3_q <= {ac_full, 2'b00};
    end
  end

  // Stage 4: discriminant magnitude and classification.
  logic                v4_q;
  logic [DW-1:0]       d4_q;
  logic [SB1_W-1:0]    sb4_q;
  logic [DW-1:0]       bb_ext, d_d;
  logic                dneg_d;
  qrs_pkg::root_case_e case_d;

  assign bb_ext = DW'(bb3_q);

  always_comb begin
    if (sg3_q) begin
      d_d    = bb_ext + ac4_3_q;
      dneg_d = 1'b0;
    end else if (bb_ext >= ac4_3_q) begin
      d_d    = bb_ext - ac4_3_q;
      dneg_d = 1'b0;
    end else begin
      d_d    = ac4_3_q - bb_ext;
      dneg_d = 1'b1;
    end
    if (az3_q) begin
      case_d = qrs_pkg::CaseDegenerate;
    end else if (dneg_d) begin
      case_d = qrs_pkg::CaseComplex;
    end else if (d_d == '0) begin
      case_d = qrs_pkg::CaseDouble;
    end else begin
      case_d = qrs_pkg::CaseTwoReal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d4_q  <= d_d;
      sb4_q <= {case_d, an3_q, bn3_q, am3_q, bm3_q};
    end
  end

  // Square root pipeline.
  qrs_pkg::pipe_ctl_t sq_ctl;
  logic               sq_valid;
  logic [RW-1:0]      sq_root;
  logic [SB1_W-1:0]   sq_sb;

  assign sq_ctl.valid = v4_q;
  assign sq_ctl.en    = en;

  qrs_isqrt #(
    .RAD_W (DW),
    .SB_W  (SB1_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sq_ctl),
    .rad_i   (d4_q),
    .sb_i    (sb4_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  // Stage 5: numerators, signs and divisor.
  qrs_pkg::root_case_e sq_case;
  logic                sq_an, sq_bn;
  logic [W-1:0]        sq_am, sq_bm;
  logic signed [NW-1:0] nb, rt, n0, n1;

  assign sq_case = qrs_pkg::root_case_e'(sq_sb[SB1_W-1 -: 2]);
  assign sq_an   = sq_sb[2*W+1];
  assign sq_bn   = sq_sb[2*W];
  assign sq_am   = sq_sb[2*W-1:W];
  assign sq_bm   = sq_sb[W-1:0];

  assign nb = sq_bn ? $signed({3'b000, sq_bm}) : -$signed({3'b000, sq_bm});
  assign rt = $signed({2'b00, sq_root});
  assign n0 = (sq_case == qrs_pkg::CaseTwoReal) ? nb + rt : nb;
  assign n1 = (sq_case == qrs_pkg::CaseTwoReal) ? nb - rt : rt;

  logic             v5_q;
  logic [NW-1:0]    mag0_q, mag1_q;
  logic [W:0]       den5_q;
  logic [SB2_W-1:0] sb5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag0_q <= n0[NW-1] ? NW'(-n0) : NW'(n0);
      mag1_q <= n1[NW-1] ? NW'(-n1) : NW'(n1);
      den5_q <= {sq_am, 1'b0};
      sb5_q  <= {sq_case, n0[NW-1] ^ sq_an, n1[NW-1] ^ sq_an};
    end
  end

  // Divider pipeline.
  qrs_pkg::pipe_ctl_t dv_ctl;
  logic               dv_valid;
  logic [QW-1:0]      quo0, quo1;
  logic [SB2_W-1:0]   dv_sb;

  assign dv_ctl.valid = v5_q;
  assign dv_ctl.en    = en;

  qrs_div #(
    .NUM_W (QW),
    .DEN_W (W + 1),
    .SB_W  (SB2_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dv_ctl),
    .num0_i  (QW'(mag0_q) << FRAC_BITS),
    .num1_i  (QW'(mag1_q) << FRAC_BITS),
    .den_i   (den5_q),
    .sb_i    (sb5_q),
    .valid_o (dv_valid),
    .quo0_o  (quo0),
    .quo1_o  (quo1),
    .sb_o    (dv_sb)
  );

  // Saturation and result selection.
  qrs_pkg::root_case_e dv_case;
  logic                neg0, neg1, sat0, sat1;
  logic [QW-1:0]       lim0, lim1, m0, m1;
  logic [W-1:0]        val0, val1;

  assign dv_case = qrs_pkg::root_case_e'(dv_sb[3:2]);
  assign neg0    = dv_sb[1];
  assign neg1    = dv_sb[0];
  assign lim0    = neg0 ? PosLim + QW'(1) : PosLim;
  assign lim1    = neg1 ? PosLim + QW'(1) : PosLim;
  assign sat0    = quo0 > lim0;
  assign sat1    = quo1 > lim1;
  assign m0      = sat0 ? lim0 : quo0;
  assign m1      = sat1 ? lim1 : quo1;
  assign val0    = neg0 ? W'(-m0[W-1:0]) : m0[W-1:0];
  assign val1    = neg1 ? W'(-m1[W-1:0]) : m1[W-1:0];

  logic [1:0]   case_q;
  logic [W-1:0] first_q, second_q, imag_q;
  logic         sat_q, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      case_q <= dv_case;
      case (dv_case)
        qrs_pkg::CaseTwoReal: begin
          first_q  <= val0;
          second_q <= val1;
          imag_q   <= '0;
          sat_q    <= sat0 | sat1;
        end
        qrs_pkg::CaseDouble: begin
          first_q  <= val0;
          second_q <= val0;
          imag_q   <= '0;
          sat_q    <= sat0;
        end
        qrs_pkg::CaseComplex: begin
          first_q  <= val0;
          second_q <= val0;
          imag_q   <= val1;
          sat_q    <= sat0 | sat1;
        end
        default: begin
          first_q  <= '0;
          second_q <= '0;
          imag_q   <= '0;
          sat_q    <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign root_case_o   = case_q;
  assign first_real_o  = first_q;
  assign second_real_o = second_q;
  assign imag_part_o   = imag_q;
  assign saturated_o   = sat_q;

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_case_o == qrs_pkg::CaseDegenerate |->
      first_real_o == '0 && second_real_o == '0 && imag_part_o == '0 && !saturated_o)
    else $error("degenerate result carries nonzero values");

  a_imag_only_complex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_case_o != qrs_pkg::CaseComplex |-> imag_part_o == '0)
    else $error("imaginary part set outside the complex case");

  a_shared_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_case_o == qrs_pkg::CaseDouble ||
                    root_case_o == qrs_pkg::CaseComplex) |->
      first_real_o == second_real_o)
    else $error("double or complex result with differing real parts");

endmodule
